// File: sv/pf2rgb_pkg.sv
// Shared types, constants and elaboration-time tables for the pixel format to RGB8 converter.
package pf2rgb_pkg;

   localparam int NumLanes      = 3;
   localparam int NumSearch     = 8;
   localparam int NumStages     = NumSearch + 2;
   localparam int CsrIndexWidth = 8;
   localparam int CsrDataWidth  = 32;

   localparam logic [CsrIndexWidth-1:0] CsrPixelFormat = CsrIndexWidth'(0);
   localparam logic [CsrIndexWidth-1:0] CsrLinearInput = CsrIndexWidth'(1);

   localparam logic [31:0] OneBits       = 32'h3F80_0000;
   localparam logic [31:0] PowFloorBits  = 32'h3B00_0000;
   localparam int unsigned FirstPowLevel = 11;
   localparam int unsigned PowNumBase    = 28050;
   localparam int unsigned PowDen        = 538050;
   localparam int unsigned LinScale      = 32946;

   typedef enum logic [2:0] {
      FMT_GRAY8       = 3'd0,
      FMT_RGB8        = 3'd1,
      FMT_RGBA8       = 3'd2,
      FMT_BGRA8       = 3'd3,
      FMT_GRAYF32     = 3'd4,
      FMT_RGBF32      = 3'd5,
      FMT_RGBAF32     = 3'd6,
      FMT_UNSUPPORTED = 3'd7
   } fmt_code_type;

   typedef enum logic [2:0] {
      KIND_ZERO,
      KIND_BYTE,
      KIND_BYTE_LIN,
      KIND_FLOAT,
      KIND_FLOAT_LIN
   } lane_kind_type;

   typedef enum logic [1:0] {
      LANE_DONE,
      LANE_ROUND,
      LANE_SHIFT,
      LANE_SEARCH
   } lane_mode_type;

   typedef struct packed {
      logic [31:0] first_channel;
      logic [31:0] second_channel;
      logic [31:0] third_channel;
   } pixel_in_type;

   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic       format_error;
   } pixel_out_type;

   typedef struct packed {
      lane_kind_type kind;
      logic [31:0]   value;
   } lane_in_type;

   // work: float bits, product or rounded product; expo: exponent, then shift count
   typedef struct packed {
      lane_mode_type mode;
      logic [31:0]   work;
      logic [7:0]    expo;
      logic [7:0]    idx;
   } lane_state_type;

   typedef struct packed {
      logic [NumStages-1:0] stage_en;
      logic                 in_stall;
      logic                 out_valid;
   } pipe_ctrl_type;

   typedef logic [255:0][30:0] level_thr_type;
   typedef logic [255:0][7:0]  byte_enc_type;

   // 255*S(x) >= k - 1/2, exact, with x given by its float bits
   function automatic logic pf_level_reached(logic [31:0] bits, int unsigned k);
      logic [511:0] lhs;
      logic [511:0] rhs;
      logic [23:0]  m;
      logic [31:0]  a;
      int           s;
      int           i;
      if (bits[30:23] == 8'd0) begin
         m = {1'b0, bits[22:0]};
         s = 149;
      end else begin
         m = {1'b1, bits[22:0]};
         s = 150 - int'(bits[30:23]);
      end
      if (k < FirstPowLevel) begin
         lhs = 512'(m) * 512'(LinScale);
         rhs = 512'(5 * (2 * k - 1)) << s;
      end else begin
         if (bits < PowFloorBits) return 1'b0;
         a   = 32'(1000 * (2 * k - 1) + PowNumBase);
         lhs = 512'd1;
         for (i = 0; i < 5; i++) lhs = lhs * 512'(m);
         for (i = 0; i < 12; i++) lhs = lhs * 512'(PowDen);
         rhs = 512'd1;
         for (i = 0; i < 12; i++) rhs = rhs * 512'(a);
         rhs = rhs << (5 * s);
      end
      return lhs >= rhs;
   endfunction

   function automatic level_thr_type pf_build_thr();
      level_thr_type thr;
      int unsigned   k;
      logic [31:0]   lo;
      logic [31:0]   hi;
      logic [31:0]   mid;
      thr = '0;
      for (k = 1; k < 256; k++) begin
         lo = 32'd1;
         hi = OneBits;
         while (lo < hi) begin
            mid = lo + ((hi - lo) >> 1);
            if (pf_level_reached(mid, k)) hi = mid;
            else lo = mid + 32'd1;
         end
         thr[k] = lo[30:0];
      end
      return thr;
   endfunction

   // nearest binary32 of b/255
   function automatic logic [31:0] pf_byte_to_float(logic [7:0] b);
      logic [63:0] num;
      logic [63:0] q;
      logic [63:0] r;
      int          s;
      if (b == 8'd0) return 32'd0;
      s   = 23;
      num = 64'(b) << s;
      q   = num / 255;
      r   = num % 255;
      while (q < 64'h80_0000 && s < 40) begin
         s   = s + 1;
         num = 64'(b) << s;
         q   = num / 255;
         r   = num % 255;
      end
      if (2 * r > 64'd255) q = q + 64'd1;
      if (q >= 64'h100_0000) begin
         q = 64'h80_0000;
         s = s - 1;
      end
      return (32'(150 - s) << 23) | (q[31:0] & 32'h007F_FFFF);
   endfunction

   function automatic byte_enc_type pf_build_byte_enc(level_thr_type thr);
      byte_enc_type enc;
      logic [31:0]  fbits;
      int unsigned  b;
      int unsigned  k;
      logic [8:0]   n;
      enc = '0;
      for (b = 1; b < 256; b++) begin
         fbits = pf_byte_to_float(8'(b));
         n     = 9'd0;
         for (k = 1; k < 256; k++)
            if (fbits >= {1'b0, thr[k]}) n = n + 9'd1;
         enc[b] = n[7:0];
      end
      return enc;
   endfunction

   localparam level_thr_type LevelThr = pf_build_thr();
   localparam byte_enc_type  ByteEnc  = pf_build_byte_enc(LevelThr);

endpackage

// File: sv/pf2rgb_decode.sv
// Input stage: routes the channel fields to the red, green and blue lanes per format.
module pf2rgb_decode (
   input  logic                                             clock,
   input  logic                                             enable,
   input  pf2rgb_pkg::fmt_code_type                         fmt_sel,
   input  logic                                             linear_input,
   input  pf2rgb_pkg::pixel_in_type                         pixel,
   output pf2rgb_pkg::lane_in_type [pf2rgb_pkg::NumLanes-1:0] lane_out,
   output logic                                             error_out
);
   import pf2rgb_pkg::*;

   lane_in_type [NumLanes-1:0] lane_ff;
   lane_in_type [NumLanes-1:0] lane_in;
   logic                       error_ff;
   logic                       error_in;
   lane_kind_type              byte_kind;
   lane_kind_type              float_kind;

   always_comb begin
      byte_kind  = linear_input ? KIND_BYTE_LIN : KIND_BYTE;
      float_kind = linear_input ? KIND_FLOAT_LIN : KIND_FLOAT;
      error_in   = 1'b0;
      lane_in[0].value = pixel.first_channel;
      lane_in[1].value = pixel.second_channel;
      lane_in[2].value = pixel.third_channel;
      lane_in[0].kind  = KIND_ZERO;
      lane_in[1].kind  = KIND_ZERO;
      lane_in[2].kind  = KIND_ZERO;
      unique case (fmt_sel)
         FMT_GRAY8, FMT_GRAYF32: begin
            for (int i = 0; i < NumLanes; i++) begin
               lane_in[i].value = pixel.first_channel;
               lane_in[i].kind  = (fmt_sel == FMT_GRAY8) ? byte_kind : float_kind;
            end
         end
         FMT_RGB8, FMT_RGBA8: begin
            for (int i = 0; i < NumLanes; i++) lane_in[i].kind = byte_kind;
         end
         FMT_BGRA8: begin
            lane_in[0].value = pixel.third_channel;
            lane_in[2].value = pixel.first_channel;
            for (int i = 0; i < NumLanes; i++) lane_in[i].kind = byte_kind;
         end
         FMT_RGBF32, FMT_RGBAF32: begin
            for (int i = 0; i < NumLanes; i++) lane_in[i].kind = float_kind;
         end
         FMT_UNSUPPORTED: begin
            error_in = 1'b1;
         end
         default: begin
            error_in = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lane_ff  <= lane_in;
         error_ff <= error_in;
      end
   end

   assign lane_out  = lane_ff;
   assign error_out = error_ff;

endmodule

// File: sv/pf2rgb_lane.sv
// One color lane: special-value screen, float scaling and sRGB level search.
module pf2rgb_lane (
   input  logic                          clock,
   input  logic [pf2rgb_pkg::NumSearch:0] lane_en,
   input  pf2rgb_pkg::lane_in_type       lane_in,
   output logic [7:0]                    result
);
   import pf2rgb_pkg::*;

   lane_state_type stage_ff [NumSearch+1];
   lane_state_type stage_in [NumSearch+1];
   logic [31:0]    product;

   // prep stage: byte paths finish here, floats get screened
   always_comb begin
      product = {8'd0, 1'b1, lane_in.value[22:0]} * 32'd255;
      stage_in[0].mode = LANE_DONE;
      stage_in[0].work = lane_in.value;
      stage_in[0].expo = lane_in.value[30:23];
      stage_in[0].idx  = 8'd0;
      unique case (lane_in.kind)
         KIND_ZERO: ;
         KIND_BYTE:     stage_in[0].idx = lane_in.value[7:0];
         KIND_BYTE_LIN: stage_in[0].idx = ByteEnc[lane_in.value[7:0]];
         KIND_FLOAT, KIND_FLOAT_LIN: begin
            if (lane_in.value[31] || lane_in.value[30:23] == 8'hFF ||
                lane_in.value == 32'd0) begin
               stage_in[0].idx = 8'd0;
            end else if (lane_in.value > OneBits) begin
               stage_in[0].idx = 8'd255;
            end else if (lane_in.kind == KIND_FLOAT_LIN) begin
               stage_in[0].mode = LANE_SEARCH;
            end else if (lane_in.value[30:23] != 8'd0) begin
               // subnormals scale to well under half a level
               stage_in[0].mode = LANE_ROUND;
               stage_in[0].work = product;
            end
         end
         default: ;
      endcase
   end

   for (genvar g = 1; g <= NumSearch; g++) begin : g_step
      localparam logic [7:0] Probe = 8'(1 << (NumSearch - g));

      logic [7:0]  cand;
      logic        sh8;
      logic [23:0] kept;
      logic [7:0]  low;
      logic [7:0]  half;
      logic        rnd_up;
      logic [24:0] p25;
      logic [7:0]  n_val;
      logic [40:0] sum;
      logic [40:0] shifted;

      always_comb begin
         cand    = stage_ff[g-1].idx | Probe;
         sh8     = stage_ff[g-1].work[31];
         kept    = sh8 ? stage_ff[g-1].work[31:8] : stage_ff[g-1].work[30:7];
         low     = sh8 ? stage_ff[g-1].work[7:0] : {1'b0, stage_ff[g-1].work[6:0]};
         half    = sh8 ? 8'h80 : 8'h40;
         rnd_up  = (low > half) || (low == half && kept[0]);
         p25     = {1'b0, kept} + 25'(rnd_up);
         n_val   = 8'd150 - stage_ff[g-1].expo - (sh8 ? 8'd8 : 8'd7);
         sum     = 41'(stage_ff[g-1].work[24:0]) + (41'd1 << (stage_ff[g-1].expo - 8'd1));
         shifted = sum >> stage_ff[g-1].expo;
         stage_in[g] = stage_ff[g-1];
         unique case (stage_ff[g-1].mode)
            LANE_DONE: ;
            LANE_ROUND: begin
               // product rounded to 24 significant bits, ties to even
               if (g == 1) begin
                  if (n_val >= 8'd40) begin
                     stage_in[g].mode = LANE_DONE;
                     stage_in[g].idx  = 8'd0;
                  end else begin
                     stage_in[g].mode = LANE_SHIFT;
                     stage_in[g].work = 32'(p25);
                     stage_in[g].expo = n_val;
                  end
               end
            end
            LANE_SHIFT: begin
               if (g == 2) begin
                  stage_in[g].mode = LANE_DONE;
                  stage_in[g].idx  = (shifted > 41'd255) ? 8'd255 : shifted[7:0];
               end
            end
            LANE_SEARCH: begin
               if ({1'b0, LevelThr[cand]} <= stage_ff[g-1].work) stage_in[g].idx = cand;
               if (g == NumSearch) stage_in[g].mode = LANE_DONE;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      for (int j = 0; j <= NumSearch; j++) begin
         if (lane_en[j]) stage_ff[j] <= stage_in[j];
      end
   end

   assign result = stage_ff[NumSearch].idx;

endmodule

// File: sv/pf2rgb_pipe_ctrl.sv
// Pipeline valid bits and per-stage advance enables with bubble squeezing.
module pf2rgb_pipe_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   input  logic                      out_stall,
   output pf2rgb_pkg::pipe_ctrl_type ctrl
);
   import pf2rgb_pkg::*;

   logic [NumStages-1:0] valid_ff;
   logic [NumStages-1:0] valid_in;
   logic [NumStages-1:0] adv;

   always_comb begin
      adv[NumStages-1] = !valid_ff[NumStages-1] || !out_stall;
      for (int i = NumStages - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
      valid_in[0] = adv[0] ? in_valid : valid_ff[0];
      for (int i = 1; i < NumStages; i++) begin
         valid_in[i] = adv[i] ? valid_ff[i-1] : valid_ff[i];
      end
      ctrl.stage_en  = adv;
      ctrl.in_stall  = !adv[0];
      ctrl.out_valid = valid_ff[NumStages-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

endmodule

// File: sv/pixel_format_to_rgb8_top.sv
// Top level of the pixel format to RGB8 converter.
// One pixel enters per clock while req_stall is low, and its RGB triple passes through an input
// decode stage, a screening stage, then eight stages that each resolve one bit of
// the sRGB output level by comparing the linear float against a 255-entry constant
// threshold table (byte inputs use a 256-entry constant lookup instead, and the
// plain float path is scaled by 255 in the screening stage, then rounded and shifted
// in the first two of those stages).
// The last stage is the output register. A stall on rsp_ holds only the stages that
// are occupied, so bubbles close up and req_ keeps being taken until the pipe is
// full. csr_ready is always high; configuration is only meant to change while no
// transaction is in flight.
module pixel_format_to_rgb8_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  pf2rgb_pkg::pixel_in_type              req_payload,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output pf2rgb_pkg::pixel_out_type             rsp_payload,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pf2rgb_pkg::CsrIndexWidth-1:0]  csr_index,
   input  logic [pf2rgb_pkg::CsrDataWidth-1:0]   csr_data
);
   import pf2rgb_pkg::*;

   fmt_code_type               fmt_sel_ff;
   logic                       linear_input_ff;
   pipe_ctrl_type              ctrl;
   lane_in_type [NumLanes-1:0] lane_in;
   logic                       dec_error;
   logic [NumStages-1:1]       err_ff;
   logic [NumLanes-1:0][7:0]   lane_res;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fmt_sel_ff      <= FMT_RGB8;
         linear_input_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         if (csr_index == CsrPixelFormat) fmt_sel_ff <= fmt_code_type'(csr_data[2:0]);
         if (csr_index == CsrLinearInput) linear_input_ff <= csr_data[0];
      end
   end

   pf2rgb_pipe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .out_stall (rsp_stall),
      .ctrl      (ctrl)
   );

   pf2rgb_decode u_decode (
      .clock        (clock),
      .enable       (ctrl.stage_en[0]),
      .fmt_sel      (fmt_sel_ff),
      .linear_input (linear_input_ff),
      .pixel        (req_payload),
      .lane_out     (lane_in),
      .error_out    (dec_error)
   );

   for (genvar l = 0; l < NumLanes; l++) begin : g_lane
      pf2rgb_lane u_lane (
         .clock   (clock),
         .lane_en (ctrl.stage_en[NumStages-1:1]),
         .lane_in (lane_in[l]),
         .result  (lane_res[l])
      );
   end

   // error flag rides alongside the lanes
   always_ff @(posedge clock) begin
      if (ctrl.stage_en[1]) err_ff[1] <= dec_error;
      for (int i = 2; i < NumStages; i++) begin
         if (ctrl.stage_en[i]) err_ff[i] <= err_ff[i-1];
      end
   end

   assign req_stall = ctrl.in_stall;
   assign rsp_valid = ctrl.out_valid;

   always_comb begin
      rsp_payload.red_out      = lane_res[0];
      rsp_payload.green_out    = lane_res[1];
      rsp_payload.blue_out     = lane_res[2];
      rsp_payload.format_error = err_ff[NumStages-1];
   end

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_payload.format_error |->
         rsp_payload.red_out == 8'd0 && rsp_payload.green_out == 8'd0 &&
         rsp_payload.blue_out == 8'd0)
      else $error("format error with nonzero color");

   a_no_stall_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_stall |-> !req_stall)
      else $error("input stalled while output drains");

   a_stall_needs_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output stage");

endmodule

// File: tb/pixel_rgb_checker.sv
// Checker for the pixel format to RGB8 converter: predicts each result and compares it.
`timescale 1ns / 1ps

module pixel_rgb_checker
   import pf2rgb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  logic                     req_stall,
   input  pixel_in_type             req_payload,
   input  logic                     rsp_valid,
   input  logic                     rsp_stall,
   input  pixel_out_type            rsp_payload,
   input  logic                     csr_valid,
   input  logic                     csr_ready,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_data,
   output int                       fail_count,
   output int                       pending_count
);

   // sRGB thresholds scaled to integers: 255*S(x) >= k - 1/2, times 510*1000 or 2550
   localparam int unsigned PowScale   = 538050;   // 510 * 1055
   localparam int unsigned PowOffset  = 28050;    // 510 * 55
   localparam int unsigned LinGain    = 32946;    // 2550 * 12.92
   localparam int unsigned KneeLevel  = 11;       // first level settled by the power segment
   localparam logic [7:0]  PowMinExp  = 8'd118;   // 2^-9, no power-segment level below it
   localparam logic [31:0] UnitBits   = 32'h3F80_0000;

   fmt_code_type     fmt_now;
   logic             lin_now;
   pixel_out_type    pending_rgb[$];
   pixel_out_type    want;

   function automatic logic reaches_level(logic [31:0] bits, int unsigned k);
      logic [511:0] lhs;
      logic [511:0] rhs;
      logic [23:0]  m;
      int           s;
      int unsigned  a;
      int           i;
      if (bits[30:23] == 8'd0) begin
         m = {1'b0, bits[22:0]};
         s = 149;
      end else begin
         m = {1'b1, bits[22:0]};
         s = 150 - int'(bits[30:23]);
      end
      if (k < KneeLevel) begin
         lhs = 512'(m) * 512'(LinGain);
         rhs = 512'(5 * (2 * k - 1)) << s;
      end else begin
         if (bits[30:23] < PowMinExp) return 1'b0;
         a   = 1000 * (2 * k - 1) + PowOffset;
         lhs = 512'd1;
         for (i = 0; i < 5; i++) lhs = lhs * 512'(m);
         for (i = 0; i < 12; i++) lhs = lhs * 512'(PowScale);
         rhs = 512'd1;
         for (i = 0; i < 12; i++) rhs = rhs * 512'(a);
         rhs = rhs << (5 * s);
      end
      return lhs >= rhs;
   endfunction

   // highest level reached; reaching is monotonic in k
   function automatic logic [7:0] srgb_level(logic [31:0] bits);
      int lo;
      int hi;
      int mid;
      lo = 0;
      hi = 255;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         if (reaches_level(bits, mid)) lo = mid;
         else hi = mid - 1;
      end
      return 8'(lo);
   endfunction

   // x * 255 rounded to binary32 (ties to even), then to integer with halves up
   function automatic logic [7:0] scale_plain(logic [31:0] bits);
      logic [23:0] m;
      logic [63:0] p;
      logic [63:0] low;
      logic [63:0] half;
      int          s;
      int          sh;
      int          n;
      int          len;
      if (bits[30:23] == 8'd0) begin
         m = {1'b0, bits[22:0]};
         s = 149;
      end else begin
         m = {1'b1, bits[22:0]};
         s = 150 - int'(bits[30:23]);
      end
      p   = 64'(m) * 64'd255;
      len = 64;
      while (len > 0 && !p[len-1]) len--;
      sh = 0;
      if (len > 24) begin
         sh   = len - 24;
         low  = p & ((64'd1 << sh) - 64'd1);
         half = 64'd1 << (sh - 1);
         p    = p >> sh;
         if (low > half || (low == half && p[0])) p = p + 64'd1;
      end
      n = s - sh;
      if (n >= 40) return 8'd0;
      p = (p + (64'd1 << (n - 1))) >> n;
      return (p > 64'd255) ? 8'd255 : p[7:0];
   endfunction

   // nearest binary32 of b / 255
   function automatic logic [31:0] byte_ratio_bits(logic [7:0] b);
      logic [63:0] q;
      logic [63:0] r;
      int          sh;
      if (b == 8'd0) return 32'd0;
      sh = 23;
      while (((64'(b) << sh) / 64'd255) < 64'h80_0000) sh++;
      q = (64'(b) << sh) / 64'd255;
      r = (64'(b) << sh) % 64'd255;
      if (2 * r > 64'd255) q = q + 64'd1;
      if (q == 64'h100_0000) begin
         q  = 64'h80_0000;
         sh = sh - 1;
      end
      return {1'b0, 8'(150 - sh), q[22:0]};
   endfunction

   function automatic logic [7:0] float_level(logic [31:0] bits, logic lin);
      if (bits[31] || bits[30:23] == 8'hFF || bits == 32'd0) return 8'd0;
      if (bits > UnitBits) return 8'd255;
      return lin ? srgb_level(bits) : scale_plain(bits);
   endfunction

   function automatic logic [7:0] byte_level(logic [31:0] word, logic lin);
      return lin ? float_level(byte_ratio_bits(word[7:0]), 1'b1) : word[7:0];
   endfunction

   function automatic pixel_out_type convert_pixel(pixel_in_type px, fmt_code_type fmt,
                                                   logic lin);
      pixel_out_type rgb;
      rgb = '0;
      case (fmt)
         FMT_GRAY8: begin
            rgb.red_out   = byte_level(px.first_channel, lin);
            rgb.green_out = rgb.red_out;
            rgb.blue_out  = rgb.red_out;
         end
         FMT_RGB8, FMT_RGBA8: begin
            rgb.red_out   = byte_level(px.first_channel, lin);
            rgb.green_out = byte_level(px.second_channel, lin);
            rgb.blue_out  = byte_level(px.third_channel, lin);
         end
         FMT_BGRA8: begin
            rgb.red_out   = byte_level(px.third_channel, lin);
            rgb.green_out = byte_level(px.second_channel, lin);
            rgb.blue_out  = byte_level(px.first_channel, lin);
         end
         FMT_GRAYF32: begin
            rgb.red_out   = float_level(px.first_channel, lin);
            rgb.green_out = rgb.red_out;
            rgb.blue_out  = rgb.red_out;
         end
         FMT_RGBF32, FMT_RGBAF32: begin
            rgb.red_out   = float_level(px.first_channel, lin);
            rgb.green_out = float_level(px.second_channel, lin);
            rgb.blue_out  = float_level(px.third_channel, lin);
         end
         default: rgb.format_error = 1'b1;
      endcase
      return rgb;
   endfunction

   task automatic check_field(input string field, input int unsigned exp_val,
                              input int unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", field, exp_val, act_val);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         fmt_now = FMT_RGB8;
         lin_now = 1'b0;
         pending_rgb.delete();
         fail_count = 0;
         pending_count <= 0;
      end else begin
         // retire before predicting so a result never matches a transaction of the same edge
         if (rsp_valid && !rsp_stall) begin
            if (pending_rgb.size() == 0) begin
               $error("result with no transaction pending: %h", rsp_payload);
               fail_count++;
            end else begin
               want = pending_rgb.pop_front();
               check_field("red_out", want.red_out, rsp_payload.red_out);
               check_field("green_out", want.green_out, rsp_payload.green_out);
               check_field("blue_out", want.blue_out, rsp_payload.blue_out);
               check_field("format_error", want.format_error, rsp_payload.format_error);
            end
         end
         if (req_valid && !req_stall)
            pending_rgb.insert(pending_rgb.size(),
                               convert_pixel(req_payload, fmt_now, lin_now));
         if (csr_valid && csr_ready) begin
            if (csr_index == CsrPixelFormat) fmt_now = fmt_code_type'(csr_data[2:0]);
            else if (csr_index == CsrLinearInput) lin_now = csr_data[0];
         end
         pending_count <= pending_rgb.size();
      end
   end

endmodule

// File: tb/tb.sv
// Testbench top for the pixel format to RGB8 converter: stimulus, clock, reset and verdict.
`timescale 1ns / 1ps

module tb;
   import pf2rgb_pkg::*;

   localparam int                     CycleLimit  = 200000;
   localparam int                     DrainCycles = 24;
   localparam logic [CsrIndexWidth-1:0] CsrUnmapped = CsrIndexWidth'(8'hA5);

   logic                     clock;
   logic                     reset;
   logic                     req_valid;
   logic                     req_stall;
   pixel_in_type             req_payload;
   logic                     rsp_valid;
   logic                     rsp_stall;
   pixel_out_type            rsp_payload;
   logic                     csr_valid;
   logic                     csr_ready;
   logic [CsrIndexWidth-1:0] csr_index;
   logic [CsrDataWidth-1:0]  csr_data;

   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   int unsigned req_idle_pct;
   int unsigned rsp_idle_pct;

   pixel_format_to_rgb8_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   pixel_rgb_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_payload   (req_payload),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_payload   (rsp_payload),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < rsp_idle_pct);
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("FAIL");
         $finish;
      end
   end

   // mostly values in (0, 1] where the encoding is interesting, plus specials and raw words
   function automatic logic [31:0] random_word();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 45) return {1'b0, 8'($urandom_range(100, 126)), 23'($urandom)};
      if (pick < 55) return {1'b0, 8'($urandom_range(0, 99)), 23'($urandom)};
      if (pick < 70) begin
         case ($urandom_range(7))
            0:       return 32'h0000_0000;
            1:       return 32'h8000_0000;
            2:       return 32'h7F80_0000;
            3:       return 32'hFF80_0000;
            4:       return 32'h7F80_0001 | 32'($urandom_range(32'h7F_FFFE));
            5:       return 32'h3F80_0000;
            6:       return 32'h3F80_0001;
            default: return 32'h7F7F_FFFF;
         endcase
      end
      return $urandom;
   endfunction

   task automatic push_pixel(input pixel_in_type px);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // hold off the sender until every transaction has come back
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CsrIndexWidth-1:0] idx,
                            input logic [CsrDataWidth-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // upper data bits are random: only the low bits of each register count
   task automatic set_mode(input fmt_code_type fmt, input logic lin);
      drain_results();
      csr_write(CsrPixelFormat, ($urandom & ~32'h7) | 32'(fmt));
      csr_write(CsrUnmapped, $urandom);
      csr_write(CsrLinearInput, ($urandom & ~32'h1) | 32'(lin));
      csr_valid <= 1'b0;
   endtask

   initial begin
      logic [3:0]  setting;
      int unsigned offset;
      int          round_no;
      int          step;
      clock        = 1'b0;
      reset        = 1'b1;
      req_valid    = 1'b0;
      req_payload  = '0;
      csr_valid    = 1'b0;
      csr_index    = '0;
      csr_data     = '0;
      req_idle_pct = 38;
      rsp_idle_pct = 47;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset configuration: rgb8, not linear; bits above the low byte are ignored
      push_pixel(pixel_in_type'{32'h0000_0000, 32'h0000_0000, 32'h0000_0000});
      push_pixel(pixel_in_type'{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF});
      push_pixel(pixel_in_type'{32'hFFFF_FF00, 32'h0000_0001, 32'h1234_5680});

      // float specials, half-way rounding, values above one
      set_mode(FMT_RGBF32, 1'b0);
      push_pixel(pixel_in_type'{32'h0000_0000, 32'h8000_0000, 32'h7FC0_0000});
      push_pixel(pixel_in_type'{32'h7F80_0000, 32'hFF80_0000, 32'h3F80_0000});
      push_pixel(pixel_in_type'{32'h0000_0001, 32'h3F00_0000, 32'h4000_0000});
      push_pixel(pixel_in_type'{32'h3F80_0001, 32'h7F7F_FFFF, 32'hBF80_0000});

      // sRGB: smallest denormal, power-segment floor, near the linear-segment knee
      set_mode(FMT_RGBF32, 1'b1);
      push_pixel(pixel_in_type'{32'h0000_0001, 32'h3B00_0000, 32'h3B4D_2E1C});
      push_pixel(pixel_in_type'{32'h3F00_0000, 32'h3F80_0000, 32'h7FFF_FFFF});
      push_pixel(pixel_in_type'{32'h3C00_0000, 32'h3E00_0000, 32'h3F7F_FFFF});

      set_mode(FMT_BGRA8, 1'b1);
      push_pixel(pixel_in_type'{32'h0000_0000, 32'h0000_0080, 32'h0000_00FF});
      push_pixel(pixel_in_type'{32'hFFFF_FF01, 32'h0000_0002, 32'h0000_00FE});
      set_mode(FMT_GRAY8, 1'b0);
      push_pixel(pixel_in_type'{32'h0000_00AB, 32'h0000_0012, 32'h0000_0034});
      set_mode(FMT_GRAY8, 1'b1);
      push_pixel(pixel_in_type'{32'h0000_007F, 32'h0000_00FF, 32'h0000_0000});
      set_mode(FMT_GRAYF32, 1'b1);
      push_pixel(pixel_in_type'{32'h3E80_0000, 32'h7F80_0000, 32'h0000_0000});
      set_mode(FMT_GRAYF32, 1'b0);
      push_pixel(pixel_in_type'{32'h3F00_0000, 32'h3F80_0000, 32'hFFFF_FFFF});
      set_mode(FMT_RGBA8, 1'b0);
      push_pixel(pixel_in_type'{32'h0000_0011, 32'h0000_0022, 32'h0000_0033});
      set_mode(FMT_RGBAF32, 1'b1);
      push_pixel(pixel_in_type'{32'h3F00_0000, 32'h3E80_0000, 32'h3D80_0000});
      set_mode(FMT_UNSUPPORTED, 1'b0);
      push_pixel(pixel_in_type'{32'hFFFF_FFFF, 32'h3F80_0000, 32'h0000_00FF});
      set_mode(FMT_UNSUPPORTED, 1'b1);
      push_pixel(pixel_in_type'{32'h3F00_0000, 32'h0000_0080, 32'h0000_0001});
      set_mode(FMT_RGB8, 1'b1);
      push_pixel(pixel_in_type'{32'h0000_0000, 32'h0000_0037, 32'h0000_00FF});

      // three rounds over all sixteen settings: receiver-heavy idling, sender-heavy, none
      for (round_no = 0; round_no < 3; round_no++) begin
         req_idle_pct <= (round_no == 0) ? 38 : (round_no == 1) ? 47 : 0;
         rsp_idle_pct <= (round_no == 0) ? 47 : (round_no == 1) ? 38 : 0;
         offset = $urandom_range(15);
         for (step = 0; step < 16; step++) begin
            setting = 4'(step + offset);
            set_mode(fmt_code_type'(setting[3:1]), setting[0]);
            repeat (13) push_pixel(pixel_in_type'{random_word(), random_word(), random_word()});
         end
      end

      drain_results();
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

// File: files.f
sv/pf2rgb_pkg.sv
sv/pf2rgb_decode.sv
sv/pf2rgb_lane.sv
sv/pf2rgb_pipe_ctrl.sv
sv/pixel_format_to_rgb8_top.sv
tb/pixel_rgb_checker.sv
tb/tb.sv
